@@ sv/gasc_pkg.sv @@
// gasc_pkg: shared types and constants of the glyph atlas shelf cache
// table entry layout, sequencer states, status codes and atlas geometry
// no dependencies
`timescale 1ns / 1ps

package gasc_pkg;

	localparam int ENTRIES = 64;
	localparam int ATLAS_W = 1024;
	localparam int ATLAS_H = 1024;

	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	localparam int KEY_W  = 16;
	localparam int DIM_W  = 10;
	localparam int BL_W   = 10;
	localparam int BT_W   = 11;
	localparam int X_W    = 10;
	localparam int TEXY_W = 10;
	localparam int Y_W    = 12;
	localparam int PAD_W  = 4;
	localparam int OPD_W  = 12;
	localparam int SUM_W  = 13;
	localparam int TMP_W  = 11;

	localparam int IN_W  = 64;
	localparam int OUT_W = 96;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  rows;
		logic [BL_W-1:0]   bleft;
		logic [BT_W-1:0]   btop;
		logic [X_W-1:0]    ax;
		logic [TEXY_W-1:0] ay;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [Y_W-1:0]   sat;
	} alu_res_t;

	typedef enum logic [1:0] {
		STAT_HIT    = 2'd0,
		STAT_PLACED = 2'd1,
		STAT_OVF    = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_BRK,
		ST_RH,
		ST_Y,
		ST_OVF,
		ST_WP,
		ST_X,
		ST_Y2,
		ST_OUT
	} state_t;

endpackage

@@ sv/gasc_ram.sv @@
// gasc_ram: generic single write port, single read port ram
// registered read data; no dependencies
`timescale 1ns / 1ps

module gasc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/gasc_alu.sv @@
// gasc_alu: shared adder of the placement sequencer
// gives the raw sum and the sum saturated to the cursor range; uses gasc_pkg
`timescale 1ns / 1ps

module gasc_alu (
	input  logic [gasc_pkg::OPD_W-1:0] a,
	input  logic [gasc_pkg::OPD_W-1:0] b,
	output gasc_pkg::alu_res_t         res
);

	logic [gasc_pkg::SUM_W-1:0] sum;

	assign sum = gasc_pkg::SUM_W'(a) + gasc_pkg::SUM_W'(b);

	always_comb begin
		res.sum = sum;
		if (sum > gasc_pkg::SUM_W'({gasc_pkg::Y_W{1'b1}})) begin
			res.sat = {gasc_pkg::Y_W{1'b1}};
		end else begin
			res.sat = sum[gasc_pkg::Y_W-1:0];
		end
	end

endmodule

@@ sv/glyph_atlas_shelf_cache.sv @@
// glyph_atlas_shelf_cache: top level, sequencer, cursor state and result register
// uses gasc_pkg, gasc_ram (entry table) and gasc_alu (shared adder)
`timescale 1ns / 1ps

// One glyph request is taken at a time: s_tready is high only while the block
// is idle. The cached entries are held in a ram and searched in fill order, one
// read per cycle, until a key matches or the last stored entry is read. A miss
// adds the shelf placement, which runs through one shared adder in the states
// BRK, RH, Y, OVF, WP, X and Y2; a miss on a full table skips the placement. The
// result is held on the master side until taken; the next request is accepted
// after that. The table is filled in order, so its fill count marks the valid
// entries and no clearing pass is needed after reset. padding may be written at
// any idle time.
module glyph_atlas_shelf_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gasc_pkg::PAD_W-1:0]  cfg_wr_data,   // padding
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// glyph_id, bmp_width, bmp_rows, bearing_left, bearing_top, zero fill
	input  logic [gasc_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status, quad_left, quad_right, quad_bottom, quad_top, tex_u_left,
	// tex_u_right, tex_v_top, tex_v_bottom, zero fill
	output logic [gasc_pkg::OUT_W-1:0]  m_tdata
);

	gasc_pkg::state_t state_q, state_d;

	logic [gasc_pkg::PAD_W-1:0]  pad_q;
	logic [gasc_pkg::CNT_W-1:0]  count_q;
	logic [gasc_pkg::X_W-1:0]    cx_q;
	logic [gasc_pkg::Y_W-1:0]    cy_q;
	logic [gasc_pkg::DIM_W-1:0]  rh_q;
	logic [gasc_pkg::TMP_W-1:0]  tmp_q;

	gasc_pkg::entry_t            req_q;
	gasc_pkg::entry_t            res_q;
	gasc_pkg::status_t           status_q;

	logic [gasc_pkg::ADDR_W-1:0] scan_addr_q;
	logic                        issued_all_q;
	logic                        pend_q;
	logic                        pend_last_q;

	logic                        in_xfer;
	logic                        out_xfer;
	logic                        rd_en;
	logic                        wr_en;
	logic                        addr_is_last;
	logic                        hit;
	logic [gasc_pkg::OPD_W-1:0]  alu_a, alu_b;
	gasc_pkg::alu_res_t          alu_res;
	gasc_pkg::entry_t            rd_data;
	gasc_pkg::entry_t            wr_data;
	logic                        ge_w, ge_h;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	assign addr_is_last = (gasc_pkg::CNT_W'(scan_addr_q) + gasc_pkg::CNT_W'(1)) == count_q;
	assign hit          = pend_q && (rd_data.key == req_q.key);
	assign ge_w         = alu_res.sum >= gasc_pkg::SUM_W'(gasc_pkg::ATLAS_W);
	assign ge_h         = alu_res.sum >= gasc_pkg::SUM_W'(gasc_pkg::ATLAS_H);

	always_comb begin
		wr_data    = req_q;
		wr_data.ax = cx_q;
		wr_data.ay = cy_q[gasc_pkg::TEXY_W-1:0];
	end

	gasc_ram #(
		.WIDTH(gasc_pkg::ENTRY_W),
		.DEPTH(gasc_pkg::ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[gasc_pkg::ADDR_W-1:0]),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(scan_addr_q),
		.rdata(rd_data)
	);

	gasc_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gasc_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = (count_q == '0) ? gasc_pkg::ST_MISS : gasc_pkg::ST_SCAN;
				end
			end
			gasc_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = gasc_pkg::ST_OUT;
				end else if (pend_q && pend_last_q) begin
					state_d = gasc_pkg::ST_MISS;
				end
			end
			gasc_pkg::ST_MISS: begin
				if (count_q >= gasc_pkg::CNT_W'(gasc_pkg::ENTRIES)) begin
					state_d = gasc_pkg::ST_OUT;
				end else begin
					state_d = gasc_pkg::ST_BRK;
				end
			end
			gasc_pkg::ST_BRK: state_d = ge_w ? gasc_pkg::ST_RH : gasc_pkg::ST_OVF;
			gasc_pkg::ST_RH:  state_d = gasc_pkg::ST_Y;
			gasc_pkg::ST_Y:   state_d = gasc_pkg::ST_OVF;
			gasc_pkg::ST_OVF: state_d = ge_h ? gasc_pkg::ST_OUT : gasc_pkg::ST_WP;
			gasc_pkg::ST_WP:  state_d = gasc_pkg::ST_X;
			gasc_pkg::ST_X:   state_d = ge_w ? gasc_pkg::ST_Y2 : gasc_pkg::ST_OUT;
			gasc_pkg::ST_Y2:  state_d = gasc_pkg::ST_OUT;
			gasc_pkg::ST_OUT: begin
				if (out_xfer) begin
					state_d = gasc_pkg::ST_IDLE;
				end
			end
			default: state_d = gasc_pkg::ST_IDLE;
		endcase
	end

	// outputs and adder operand selection
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		alu_a    = '0;
		alu_b    = '0;
		case (state_q)
			gasc_pkg::ST_IDLE: s_tready = 1'b1;
			gasc_pkg::ST_SCAN: rd_en = !issued_all_q;
			gasc_pkg::ST_BRK: begin
				alu_a = gasc_pkg::OPD_W'(cx_q);
				alu_b = gasc_pkg::OPD_W'(req_q.width);
			end
			gasc_pkg::ST_RH: begin
				alu_a = gasc_pkg::OPD_W'(rh_q);
				alu_b = gasc_pkg::OPD_W'(pad_q);
			end
			gasc_pkg::ST_Y: begin
				alu_a = cy_q;
				alu_b = gasc_pkg::OPD_W'(tmp_q);
			end
			gasc_pkg::ST_OVF: begin
				alu_a = cy_q;
				alu_b = gasc_pkg::OPD_W'(req_q.rows);
				wr_en = !ge_h;
			end
			gasc_pkg::ST_WP: begin
				alu_a = gasc_pkg::OPD_W'(req_q.width);
				alu_b = gasc_pkg::OPD_W'(pad_q);
			end
			gasc_pkg::ST_X: begin
				alu_a = gasc_pkg::OPD_W'(cx_q);
				alu_b = gasc_pkg::OPD_W'(tmp_q);
			end
			gasc_pkg::ST_Y2: begin
				alu_a = cy_q;
				alu_b = gasc_pkg::OPD_W'(rh_q);
			end
			gasc_pkg::ST_OUT: m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gasc_pkg::ST_IDLE;
			pad_q        <= gasc_pkg::PAD_W'(1);
			count_q      <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			rh_q         <= '0;
			scan_addr_q  <= '0;
			issued_all_q <= 1'b0;
			pend_q       <= 1'b0;
			pend_last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				pad_q <= cfg_wr_data;
			end
			case (state_q)
				gasc_pkg::ST_IDLE: begin
					scan_addr_q  <= '0;
					issued_all_q <= 1'b0;
					pend_q       <= 1'b0;
					pend_last_q  <= 1'b0;
				end
				gasc_pkg::ST_SCAN: begin
					// read data arrives in the cycle after the address
					pend_q      <= rd_en;
					pend_last_q <= rd_en && addr_is_last;
					if (rd_en) begin
						scan_addr_q <= scan_addr_q + gasc_pkg::ADDR_W'(1);
						if (addr_is_last) begin
							issued_all_q <= 1'b1;
						end
					end
				end
				gasc_pkg::ST_Y: begin
					cy_q <= alu_res.sat;
					cx_q <= '0;
					rh_q <= '0;
				end
				gasc_pkg::ST_OVF: begin
					if (!ge_h) begin
						if (req_q.rows > rh_q) begin
							rh_q <= req_q.rows;
						end
						count_q <= count_q + gasc_pkg::CNT_W'(1);
					end
				end
				gasc_pkg::ST_X: begin
					cx_q <= ge_w ? '0 : alu_res.sum[gasc_pkg::X_W-1:0];
				end
				gasc_pkg::ST_Y2: begin
					cy_q <= alu_res.sat;
					rh_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q.key   <= s_tdata[15:0];
			req_q.width <= s_tdata[25:16];
			req_q.rows  <= s_tdata[35:26];
			req_q.bleft <= s_tdata[45:36];
			req_q.btop  <= s_tdata[56:46];
			req_q.ax    <= '0;
			req_q.ay    <= '0;
		end
		case (state_q)
			gasc_pkg::ST_SCAN: begin
				if (hit) begin
					res_q    <= rd_data;
					status_q <= gasc_pkg::STAT_HIT;
				end
			end
			gasc_pkg::ST_MISS: begin
				if (count_q >= gasc_pkg::CNT_W'(gasc_pkg::ENTRIES)) begin
					res_q    <= '0;
					status_q <= gasc_pkg::STAT_FULL;
				end
			end
			gasc_pkg::ST_RH: tmp_q <= alu_res.sum[gasc_pkg::TMP_W-1:0];
			gasc_pkg::ST_OVF: begin
				if (ge_h) begin
					res_q    <= '0;
					status_q <= gasc_pkg::STAT_OVF;
				end else begin
					res_q    <= wr_data;
					status_q <= gasc_pkg::STAT_PLACED;
				end
			end
			gasc_pkg::ST_WP: tmp_q <= alu_res.sum[gasc_pkg::TMP_W-1:0];
			default: ;
		endcase
	end

	// result fields from the held record
	logic [11:0] quad_right, quad_bottom;
	logic [10:0] tex_u_right, tex_v_bottom;

	assign quad_right   = {{2{res_q.bleft[9]}}, res_q.bleft} + {2'b00, res_q.width};
	assign quad_bottom  = {res_q.btop[10], res_q.btop} - {2'b00, res_q.rows};
	assign tex_u_right  = {1'b0, res_q.ax} + {1'b0, res_q.width};
	assign tex_v_bottom = {1'b0, res_q.ay} + {1'b0, res_q.rows};

	assign m_tdata = {
		7'd0,
		tex_v_bottom,
		res_q.ay,
		tex_u_right,
		res_q.ax,
		res_q.btop,
		quad_bottom,
		quad_right,
		res_q.bleft,
		status_q
	};

endmodule

@@ bench/glyph_quad_checker.sv @@
// glyph_quad_checker: watches the request, result and padding ports of the glyph atlas cache
// keeps its own glyph table and shelf cursor, predicts each quad and compares field by field
// uses gasc_pkg for sizes and status codes
`timescale 1ns / 1ps

module glyph_quad_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gasc_pkg::PAD_W-1:0]  cfg_wr_data,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [gasc_pkg::IN_W-1:0]   s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [gasc_pkg::OUT_W-1:0]  m_tdata,
	output int                          fail_count,
	output int                          pending
);

	import gasc_pkg::*;

	localparam int Y_SAT = (1 << Y_W) - 1;

	typedef struct packed {
		int width;
		int rows;
		int bleft;
		int btop;
		int ax;
		int ay;
	} placed_glyph_t;

	typedef struct packed {
		status_t     status;
		logic [9:0]  quad_left;
		logic [11:0] quad_right;
		logic [11:0] quad_bottom;
		logic [10:0] quad_top;
		logic [9:0]  u_left;
		logic [10:0] u_right;
		logic [9:0]  v_top;
		logic [10:0] v_bottom;
	} quad_t;

	bit            glyph_valid [ENTRIES];
	logic [15:0]   glyph_key [ENTRIES];
	placed_glyph_t glyph_place [ENTRIES];
	int            glyph_count;
	int            cur_x;
	int            cur_y;
	int            shelf_h;
	int            pad;
	int            result_no;
	quad_t         expected_quads [$];
	quad_t         next_quad;

	task automatic report_mismatch(input string what);
		$display("result %0d: %s", result_no, what);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [11:0] want,
			input logic [11:0] got);
		if (want !== got)
			report_mismatch($sformatf("%s expected %h got %h", name, want, got));
	endtask

	function automatic quad_t build_quad(input status_t st, input placed_glyph_t g);
		quad_t q;
		int    v;
		q.status = st;
		v = g.bleft;
		q.quad_left = v[9:0];
		v = g.bleft + g.width;
		q.quad_right = v[11:0];
		v = g.btop - g.rows;
		q.quad_bottom = v[11:0];
		v = g.btop;
		q.quad_top = v[10:0];
		v = g.ax;
		q.u_left = v[9:0];
		v = g.ax + g.width;
		q.u_right = v[10:0];
		v = g.ay;
		q.v_top = v[9:0];
		v = g.ay + g.rows;
		q.v_bottom = v[10:0];
		return q;
	endfunction

	function automatic int advance_y(input int y, input int d);
		return (y + d > Y_SAT) ? Y_SAT : y + d;
	endfunction

	// search in fill order, otherwise shelf placement of the new bitmap
	task automatic lookup_or_place(input logic [IN_W-1:0] d, output quad_t q);
		logic [15:0]   id;
		placed_glyph_t g;
		placed_glyph_t blank;
		bit            hit;
		id = d[15:0];
		blank = '0;
		hit = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!hit && glyph_valid[i] && glyph_key[i] == id) begin
				q = build_quad(STAT_HIT, glyph_place[i]);
				hit = 1'b1;
			end
		end
		if (hit)
			return;
		if (glyph_count >= ENTRIES) begin
			q = build_quad(STAT_FULL, blank);
			return;
		end
		g = blank;
		g.width = int'(d[25:16]);
		g.rows = int'(d[35:26]);
		g.bleft = int'($signed(d[45:36]));
		g.btop = int'($signed(d[56:46]));
		if (cur_x + g.width >= ATLAS_W) begin
			cur_y = advance_y(cur_y, shelf_h + pad);
			cur_x = 0;
			shelf_h = 0;
		end
		// the row break above stays even when the glyph does not fit
		if (cur_y + g.rows >= ATLAS_H) begin
			q = build_quad(STAT_OVF, blank);
			return;
		end
		if (g.rows > shelf_h)
			shelf_h = g.rows;
		g.ax = cur_x;
		g.ay = cur_y;
		glyph_valid[glyph_count] = 1'b1;
		glyph_key[glyph_count] = id;
		glyph_place[glyph_count] = g;
		glyph_count++;
		cur_x = cur_x + g.width + pad;
		if (cur_x >= ATLAS_W) begin
			cur_x = 0;
			cur_y = advance_y(cur_y, shelf_h);
			shelf_h = 0;
		end
		q = build_quad(STAT_PLACED, g);
	endtask

	task automatic check_result(input logic [OUT_W-1:0] d);
		quad_t want;
		if (expected_quads.size() == 0) begin
			report_mismatch("result transfer with nothing outstanding");
		end else begin
			want = expected_quads.pop_front();
			compare_field("status", 12'(want.status), 12'(d[1:0]));
			compare_field("quad_left", 12'(want.quad_left), 12'(d[11:2]));
			compare_field("quad_right", want.quad_right, d[23:12]);
			compare_field("quad_bottom", want.quad_bottom, d[35:24]);
			compare_field("quad_top", 12'(want.quad_top), 12'(d[46:36]));
			compare_field("tex_u_left", 12'(want.u_left), 12'(d[56:47]));
			compare_field("tex_u_right", 12'(want.u_right), 12'(d[67:57]));
			compare_field("tex_v_top", 12'(want.v_top), 12'(d[77:68]));
			compare_field("tex_v_bottom", 12'(want.v_bottom), 12'(d[88:78]));
			compare_field("zero fill", '0, 12'(d[OUT_W-1:89]));
		end
		result_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				glyph_valid[i] = 1'b0;
			glyph_count = 0;
			cur_x = 0;
			cur_y = 0;
			shelf_h = 0;
			pad = 1;
			result_no = 0;
			fail_count = 0;
			expected_quads.delete();
			pending = 0;
		end else begin
			// the older result leaves before a new request is predicted
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready) begin
				lookup_or_place(s_tdata, next_quad);
				expected_quads.push_back(next_quad);
			end
			if (cfg_wr_en)
				pad = int'(cfg_wr_data);
			pending = expected_quads.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// testbench: top of the glyph atlas cache bench, drives glyph requests, result back-pressure
// and padding writes, and gives the verdict
// uses gasc_pkg, glyph_atlas_shelf_cache and glyph_quad_checker
`timescale 1ns / 1ps

module testbench;

	import gasc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 80;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [PAD_W-1:0]  cfg_wr_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	int          fail_count;
	int          pending;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          stuck_cycles = 0;
	logic [15:0] cached_ids [$];

	glyph_atlas_shelf_cache dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	glyph_quad_checker quad_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side back-pressure in bursts
	always begin
		@(negedge clk);
		if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_glyph(input logic [15:0] id, input logic [9:0] w, input logic [9:0] rows,
			input logic [9:0] bl, input logic [10:0] bt);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tdata  <= {7'd0, bt, bl, rows, w, id};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// padding only changes once every result is back and the block has gone quiet
	task automatic set_padding(input logic [PAD_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// miss_pm: new small glyphs per thousand, the rest mostly repeats of cached ids
	task automatic random_glyph(input int miss_pm);
		int          sel;
		logic [15:0] id;
		sel = $urandom_range(0, 999);
		id = 16'($urandom);
		if (sel < miss_pm || cached_ids.size() == 0) begin
			cached_ids.push_back(id);
			send_glyph(id, 10'($urandom_range(0, 40)), 10'($urandom_range(0, 24)),
				10'($urandom), 11'($urandom));
		end else if (sel < miss_pm + 20) begin
			// too tall for what is left of the atlas
			send_glyph(id, 10'($urandom_range(0, 31)), 10'd1023, 10'($urandom), 11'($urandom));
		end else if (sel < miss_pm + 25) begin
			cached_ids.push_back(id);
			send_glyph(id, 10'($urandom_range(512, 1023)), 10'($urandom_range(0, 15)),
				10'($urandom), 11'($urandom));
		end else begin
			send_glyph(cached_ids[$urandom_range(0, cached_ids.size() - 1)],
				10'($urandom), 10'($urandom), 10'($urandom), 11'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset padding, corner placements and hits
		gap_pct = 25;
		stall_pct = 10;
		send_glyph(16'h0000, 10'd0, 10'd0, 10'h200, 11'h400);
		cached_ids.push_back(16'h0000);
		send_glyph(16'h0000, 10'h3FF, 10'h3FF, 10'h1FF, 11'h3FF);
		// row break before placement, then a second one after it
		send_glyph(16'hFFFF, 10'h3FF, 10'd10, 10'h1FF, 11'h3FF);
		cached_ids.push_back(16'hFFFF);
		send_glyph(16'hA5A5, 10'd5, 10'h3FF, 10'd0, 11'd0);
		send_glyph(16'h0101, 10'd100, 10'd50, 10'h3C0, 11'h7F0);
		cached_ids.push_back(16'h0101);
		// row break kept although the glyph overflows
		send_glyph(16'h0202, 10'd1000, 10'd1000, 10'd0, 11'd0);
		send_glyph(16'hFFFF, 10'd0, 10'd0, 10'd0, 11'd0);
		send_glyph(16'h0101, 10'($urandom), 10'($urandom), 10'($urandom), 11'($urandom));
		send_glyph(16'h0202, 10'h3FF, 10'd0, 10'h200, 11'h400);
		cached_ids.push_back(16'h0202);
		send_glyph(16'h0303, 10'd0, 10'd0, 10'h1FF, 11'd0);
		cached_ids.push_back(16'h0303);
		send_glyph(16'h0202, 10'($urandom), 10'($urandom), 10'($urandom), 11'($urandom));

		set_padding(4'd0);
		gap_pct = 20;
		stall_pct = 10;
		repeat (400) random_glyph(25);

		set_padding(4'd15);
		gap_pct = 0;
		stall_pct = 0;
		repeat (400) random_glyph(25);

		set_padding(4'($urandom_range(2, 14)));
		gap_pct = 60;
		stall_pct = 30;
		repeat (400) random_glyph(25);

		set_padding(4'($urandom_range(0, 15)));
		gap_pct = 15;
		stall_pct = 5;
		repeat (400) random_glyph(25);

		// flood of new glyphs to fill the table, no idling from here on
		gap_pct = 0;
		stall_pct = 0;
		repeat (200) random_glyph(400);

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
